[hw/rtl/ber_tlv_stream_parser_macros.svh]
// Assertion macros shared by the BER-TLV stream parser RTL.
`ifndef BER_TLV_STREAM_PARSER_MACROS_SVH
`define BER_TLV_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BERTLV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BERTLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bertlv_pkg.sv]
// Shared types and constants of the BER-TLV stream parser.
`default_nettype none

package bertlv_pkg;

   localparam int MAX_DEPTH     = 8;
   localparam int MAX_LEN_BYTES = 4;

   localparam int POS_W   = 32;
   localparam int COUNT_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LEFT_W  = $clog2(MAX_LEN_BYTES + 1);
   localparam int CLOSE_W = COUNT_W + 1;

   localparam logic [7:0] CONS_BIT  = 8'h20;
   localparam logic [7:0] TAG_MASK  = 8'h1f;
   localparam logic [7:0] LONG_BIT  = 8'h80;
   localparam logic [7:0] COUNT_MSK = 8'h7f;

   typedef enum logic [1:0] {
      PH_TAG = 2'd0,
      PH_LEN = 2'd1,
      PH_VAL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TAG = 2'd0,
      KIND_LEN = 2'd1,
      KIND_VAL = 2'd2,
      KIND_IGN = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_LONG_LEN  = 3'd1,
      ERR_TOO_DEEP  = 3'd2,
      ERR_OVERRUN   = 3'd3,
      ERR_TRUNCATED = 3'd4
   } err_type;

   // Registered request
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // One result
   typedef struct packed {
      kind_type          byte_kind;
      logic              tag_start;
      logic              constructed;
      logic [3:0]        depth;
      logic              header_done;
      logic [POS_W-1:0]  value_length;
      logic [3:0]        elements_closed;
      err_type           error_code;
      logic              stream_end;
   } rsp_type;

   // Core -> stack: lookup and write
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [POS_W:0]     next_pos;
      logic               we;
      logic [IDX_W-1:0]   wr_idx;
      logic [POS_W-1:0]   wr_end;
   } stk_req_type;

   // Stack -> core
   typedef struct packed {
      logic [POS_W-1:0]   top_end;
      logic [COUNT_W-1:0] keep_count;
   } stk_stat_type;

   // Core status for checks
   typedef struct packed {
      phase_type          phase;
      logic [COUNT_W-1:0] count;
      err_type            err_latch;
   } core_stat_type;

endpackage

`default_nettype wire

[hw/rtl/bertlv_in_reg.sv]
// Input register of the BER-TLV stream parser.
`default_nettype none

module bertlv_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_last_byte,
   input  wire logic             take,
   output bertlv_pkg::req_type   held
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign held.valid     = valid_ff;
   assign held.data_byte = data_ff;
   assign held.last_byte = last_ff;

endmodule

`default_nettype wire

[hw/rtl/bertlv_stack.sv]
// End-position stack of open constructed elements, with parallel close compare.
`default_nettype none

module bertlv_stack (
   input  wire logic                   clock,
   input  wire bertlv_pkg::stk_req_type stk_req,
   output bertlv_pkg::stk_stat_type    stk_stat
);

   logic [bertlv_pkg::POS_W-1:0]   ent_ff [bertlv_pkg::MAX_DEPTH];
   logic [bertlv_pkg::MAX_DEPTH-1:0] match;
   logic [bertlv_pkg::IDX_W-1:0]   top_idx;
   logic [bertlv_pkg::COUNT_W-1:0] keep;

   always_ff @(posedge clock) begin
      if (stk_req.we) begin
         ent_ff[stk_req.wr_idx] <= stk_req.wr_end;
      end
   end

   // Entries shrink toward the top; the closing ones form a run at the top.
   always_comb begin
      for (int i = 0; i < bertlv_pkg::MAX_DEPTH; i++) begin
         match[i] = ({1'b0, ent_ff[i]} == stk_req.next_pos);
      end
   end

   always_comb begin
      keep = '0;
      for (int i = 0; i < bertlv_pkg::MAX_DEPTH; i++) begin
         if ((bertlv_pkg::COUNT_W'(i) < stk_req.count) && !match[i]) begin
            keep = bertlv_pkg::COUNT_W'(i + 1);
         end
      end
   end

   assign top_idx = bertlv_pkg::IDX_W'(stk_req.count - bertlv_pkg::COUNT_W'(1));

   assign stk_stat.top_end    = ent_ff[top_idx];
   assign stk_stat.keep_count = keep;

endmodule

`default_nettype wire

[hw/rtl/bertlv_core.sv]
// Per-byte decode and parser state of the BER-TLV stream parser.
`default_nettype none

module bertlv_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire bertlv_pkg::req_type      held,
   input  wire bertlv_pkg::stk_stat_type stk_stat,
   output bertlv_pkg::stk_req_type       stk_req,
   output bertlv_pkg::rsp_type           rsp,
   output bertlv_pkg::core_stat_type     core_stat
);

   bertlv_pkg::phase_type          phase_ff, phase_in;
   logic                           tagc_ff, tagc_in;
   logic                           cons_ff, cons_in;
   logic [bertlv_pkg::LEFT_W-1:0]  left_ff, left_in;
   logic [bertlv_pkg::POS_W-1:0]   accum_ff, accum_in;
   logic [bertlv_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [bertlv_pkg::POS_W-1:0]   prim_end_ff, prim_end_in;
   logic [bertlv_pkg::COUNT_W-1:0] count_ff, count_in;
   bertlv_pkg::err_type            latch_ff, latch_in;

   logic [bertlv_pkg::POS_W:0]     nxt;
   logic [bertlv_pkg::POS_W:0]     end_sum;
   logic [7:0]                     b;
   logic [6:0]                     n;
   logic                           has_parent;
   logic                           overrun_hdr;
   logic                           done;
   logic                           push;
   logic                           close_one;
   logic [bertlv_pkg::COUNT_W-1:0] pop;
   logic [bertlv_pkg::CLOSE_W-1:0] closed;
   bertlv_pkg::err_type            err;

   assign b           = held.data_byte;
   assign n           = b[6:0];
   assign nxt         = {1'b0, pos_ff} + (bertlv_pkg::POS_W + 1)'(1);
   assign has_parent  = (count_ff != '0);
   assign overrun_hdr = has_parent && (pos_ff >= stk_stat.top_end);
   assign pop         = count_ff - stk_stat.keep_count;

   always_comb begin
      phase_in    = phase_ff;
      tagc_in     = tagc_ff;
      cons_in     = cons_ff;
      left_in     = left_ff;
      accum_in    = accum_ff;
      prim_end_in = prim_end_ff;
      count_in    = count_ff;
      latch_in    = latch_ff;
      pos_in      = nxt[bertlv_pkg::POS_W-1:0];
      end_sum     = '0;
      done        = 1'b0;
      push        = 1'b0;
      close_one   = 1'b0;
      closed      = '0;
      err         = bertlv_pkg::ERR_NONE;
      rsp         = '0;
      rsp.byte_kind  = bertlv_pkg::KIND_TAG;
      rsp.error_code = bertlv_pkg::ERR_NONE;
      rsp.stream_end = held.last_byte;

      if (latch_ff != bertlv_pkg::ERR_NONE) begin
         rsp.byte_kind = bertlv_pkg::KIND_IGN;
         err = latch_ff;
      end else begin
         rsp.depth = 4'(count_ff);
         if (phase_ff == bertlv_pkg::PH_VAL) begin
            rsp.byte_kind = bertlv_pkg::KIND_VAL;
            if (nxt == {1'b0, prim_end_ff}) begin
               close_one = 1'b1;
               phase_in  = bertlv_pkg::PH_TAG;
            end
         end else if (overrun_hdr) begin
            rsp.byte_kind   = (phase_ff == bertlv_pkg::PH_TAG) ? bertlv_pkg::KIND_TAG
                                                               : bertlv_pkg::KIND_LEN;
            rsp.constructed = cons_ff;
            err = bertlv_pkg::ERR_OVERRUN;
         end else if (phase_ff == bertlv_pkg::PH_TAG) begin
            rsp.byte_kind = bertlv_pkg::KIND_TAG;
            if (!tagc_ff) begin
               rsp.tag_start = 1'b1;
               cons_in = ((b & bertlv_pkg::CONS_BIT) != '0);
               tagc_in = ((b & bertlv_pkg::TAG_MASK) == bertlv_pkg::TAG_MASK);
            end else begin
               tagc_in = ((b & bertlv_pkg::LONG_BIT) != '0);
            end
            if (!tagc_in) begin
               phase_in = bertlv_pkg::PH_LEN;
            end
            rsp.constructed = cons_in;
         end else begin
            rsp.byte_kind   = bertlv_pkg::KIND_LEN;
            rsp.constructed = cons_ff;
            if (left_ff == '0) begin
               if ((b & bertlv_pkg::LONG_BIT) != '0) begin
                  if (n > 7'(bertlv_pkg::MAX_LEN_BYTES)) begin
                     err = bertlv_pkg::ERR_LONG_LEN;
                  end else if (n == '0) begin
                     accum_in = '0;
                     done     = 1'b1;
                  end else begin
                     left_in  = n[bertlv_pkg::LEFT_W-1:0];
                     accum_in = '0;
                  end
               end else begin
                  accum_in = bertlv_pkg::POS_W'(b & bertlv_pkg::COUNT_MSK);
                  done     = 1'b1;
               end
            end else begin
               if (accum_ff[bertlv_pkg::POS_W-1 -: 8] != '0) begin
                  err = bertlv_pkg::ERR_LONG_LEN;
               end else begin
                  accum_in = {accum_ff[bertlv_pkg::POS_W-9:0], b};
                  left_in  = left_ff - bertlv_pkg::LEFT_W'(1);
                  done     = (left_ff == bertlv_pkg::LEFT_W'(1));
               end
            end

            if (done) begin
               end_sum          = nxt + {1'b0, accum_in};
               rsp.header_done  = 1'b1;
               rsp.value_length = accum_in;
               phase_in         = bertlv_pkg::PH_TAG;
               left_in          = '0;
               if (end_sum[bertlv_pkg::POS_W] ||
                   (has_parent &&
                    (end_sum[bertlv_pkg::POS_W-1:0] > stk_stat.top_end))) begin
                  err = bertlv_pkg::ERR_OVERRUN;
               end else if (accum_in == '0) begin
                  close_one = 1'b1;
               end else if (cons_ff) begin
                  if (count_ff >= bertlv_pkg::COUNT_W'(bertlv_pkg::MAX_DEPTH)) begin
                     err = bertlv_pkg::ERR_TOO_DEEP;
                  end else begin
                     push = 1'b1;
                  end
               end else begin
                  prim_end_in = end_sum[bertlv_pkg::POS_W-1:0];
                  phase_in    = bertlv_pkg::PH_VAL;
               end
            end
         end

         if (err == bertlv_pkg::ERR_NONE) begin
            // a push never coincides with a pop: its end lies past the next byte
            if (push) begin
               count_in = count_ff + bertlv_pkg::COUNT_W'(1);
            end else begin
               count_in = stk_stat.keep_count;
               closed   = bertlv_pkg::CLOSE_W'(close_one) + bertlv_pkg::CLOSE_W'(pop);
            end
            if (!push && close_one) begin
               closed = bertlv_pkg::CLOSE_W'(close_one) + bertlv_pkg::CLOSE_W'(pop);
            end
            if (held.last_byte &&
                ((phase_in != bertlv_pkg::PH_TAG) || tagc_in || (count_in != '0))) begin
               err = bertlv_pkg::ERR_TRUNCATED;
            end
         end
         if (err != bertlv_pkg::ERR_NONE) begin
            latch_in = err;
         end
         rsp.elements_closed = 4'(closed);
      end

      rsp.error_code = err;

      // end of stream: back to the reset state
      if (held.last_byte) begin
         phase_in    = bertlv_pkg::PH_TAG;
         tagc_in     = 1'b0;
         cons_in     = 1'b0;
         left_in     = '0;
         accum_in    = '0;
         pos_in      = '0;
         prim_end_in = '0;
         count_in    = '0;
         latch_in    = bertlv_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bertlv_pkg::PH_TAG;
         tagc_ff     <= 1'b0;
         cons_ff     <= 1'b0;
         left_ff     <= '0;
         accum_ff    <= '0;
         pos_ff      <= '0;
         prim_end_ff <= '0;
         count_ff    <= '0;
         latch_ff    <= bertlv_pkg::ERR_NONE;
      end else if (fire) begin
         phase_ff    <= phase_in;
         tagc_ff     <= tagc_in;
         cons_ff     <= cons_in;
         left_ff     <= left_in;
         accum_ff    <= accum_in;
         pos_ff      <= pos_in;
         prim_end_ff <= prim_end_in;
         count_ff    <= count_in;
         latch_ff    <= latch_in;
      end
   end

   assign stk_req.count    = count_ff;
   assign stk_req.next_pos = nxt;
   assign stk_req.we       = fire && push;
   assign stk_req.wr_idx   = bertlv_pkg::IDX_W'(count_ff);
   assign stk_req.wr_end   = end_sum[bertlv_pkg::POS_W-1:0];

   assign core_stat.phase     = phase_ff;
   assign core_stat.count     = count_ff;
   assign core_stat.err_latch = latch_ff;

endmodule

`default_nettype wire

[hw/rtl/ber_tlv_stream_parser.sv]
// Top level of the BER-TLV stream parser: input register, decode core, output register.
`default_nettype none

// Parses a binary BER-TLV stream one byte per request and returns one result per
// byte: tag, length or value kind, nesting depth, constructed flag, the decoded
// length on the byte that ends a header, the number of elements that end on the
// byte, and an error code (long length over four bytes, nesting deeper than eight,
// child running past its parent, stream ending inside an element). After an error
// every byte up to the one marked last_byte comes back as ignored with the latched
// code; the byte marked last_byte always returns the parser to its reset state for
// the next stream. Throughput is one byte per clock while rsp_stall is low: a request is
// registered in the input register, then decoded against the parser state into the
// output register. The per-byte cost is set by the length path (one 33-bit add of
// position and length, then a compare against the innermost open end); the open ends
// are held in an eight-entry register stack and all of them are compared with the
// next position in parallel so that any number of nested elements can close on the
// same byte. Back-pressure on rsp_stall reaches req_stall in the same cycle only when
// both registers are full.

`include "ber_tlv_stream_parser_macros.svh"

module ber_tlv_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_byte_kind,
   output logic             rsp_tag_start,
   output logic             rsp_constructed,
   output logic [3:0]       rsp_depth,
   output logic             rsp_header_done,
   output logic [31:0]      rsp_value_length,
   output logic [3:0]       rsp_elements_closed,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_stream_end
);

   bertlv_pkg::req_type       held;
   bertlv_pkg::stk_req_type   stk_req;
   bertlv_pkg::stk_stat_type  stk_stat;
   bertlv_pkg::rsp_type       rsp_next;
   bertlv_pkg::rsp_type       rsp_ff;
   bertlv_pkg::core_stat_type core_stat;

   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic take;

   // The output register frees up when empty or when its result is taken now.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = held.valid && out_free;

   bertlv_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .take          (take),
      .held          (held)
   );

   bertlv_stack u_stack (
      .clock    (clock),
      .stk_req  (stk_req),
      .stk_stat (stk_stat)
   );

   // Decode and state update happen on the cycle the request moves to the output.
   bertlv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (take),
      .held      (held),
      .stk_stat  (stk_stat),
      .stk_req   (stk_req),
      .rsp       (rsp_next),
      .core_stat (core_stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_kind       = rsp_ff.byte_kind;
   assign rsp_tag_start       = rsp_ff.tag_start;
   assign rsp_constructed     = rsp_ff.constructed;
   assign rsp_depth           = rsp_ff.depth;
   assign rsp_header_done     = rsp_ff.header_done;
   assign rsp_value_length    = rsp_ff.value_length;
   assign rsp_elements_closed = rsp_ff.elements_closed;
   assign rsp_error_code      = rsp_ff.error_code;
   assign rsp_stream_end      = rsp_ff.stream_end;

   // Checks

   // the last byte of a stream always leaves a clean parser
   `BERTLV_ASSERT_NEXT(a_last_clears, clock, reset, take && held.last_byte, (core_stat.count == '0) && (core_stat.err_latch == bertlv_pkg::ERR_NONE) && (core_stat.phase == bertlv_pkg::PH_TAG), "parser state not cleared after last byte")

   // the open-element stack never goes past its depth
   `BERTLV_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, core_stat.count <= bertlv_pkg::COUNT_W'(bertlv_pkg::MAX_DEPTH), "stack count beyond depth")

   // an ignored byte only ever follows a latched error
   `BERTLV_ASSERT_NOW(a_ign_has_err, clock, reset, rsp_valid_ff && (rsp_ff.byte_kind == bertlv_pkg::KIND_IGN), rsp_ff.error_code != bertlv_pkg::ERR_NONE, "ignored byte without error code")

   // a header ends only on a length byte
   `BERTLV_ASSERT_NOW(a_hdr_on_len, clock, reset, rsp_valid_ff && rsp_ff.header_done, rsp_ff.byte_kind == bertlv_pkg::KIND_LEN, "header done on non-length byte")

   // with the output register empty, requests are never held off
   `BERTLV_ASSERT_NOW(a_no_false_stall, clock, reset, !rsp_valid_ff, !req_stall, "stall with empty output register")

endmodule

`default_nettype wire
